// File: rtl/fsf_pkg.sv
package fsf_pkg;

	localparam int MAX_WIDTH = 11;
	// An octal rendering of a 32-bit word is the longest run of digits.
	localparam int DIG_MAX = 11;
	localparam int OUT_MAX = (MAX_WIDTH > DIG_MAX) ? MAX_WIDTH : DIG_MAX;
	localparam int FW_W = $clog2(MAX_WIDTH + 1);
	localparam int CNT_W = $clog2(OUT_MAX + 1);
	localparam int DIG_IDX_W = $clog2(DIG_MAX);
	localparam logic [31:0] RECIP10 = 32'hCCCCCCCD;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PCT = 8'h25;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	localparam logic [7:0] HEX_DIGITS [16] = '{
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
		8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
	};

	typedef enum logic [1:0] {
		KIND_CHAR    = 2'd0,
		KIND_STR_REQ = 2'd1,
		KIND_END     = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		BASE_DEC = 2'd0,
		BASE_HEX = 2'd1,
		BASE_OCT = 2'd2
	} base_t;

	typedef enum logic {
		FIRST_CR  = 1'b0,
		FIRST_PCT = 1'b1
	} first_sel_t;

	typedef enum logic [2:0] {
		SEC_CHAR = 3'd0,
		SEC_PCT  = 3'd1,
		SEC_ARG  = 3'd2,
		SEC_END  = 3'd3,
		SEC_REQ  = 3'd4
	} second_sel_t;

	typedef enum logic [1:0] {
		EMIT_FIRST  = 2'd0,
		EMIT_SECOND = 2'd1,
		EMIT_DIGIT  = 2'd2
	} emit_sel_t;

	typedef struct packed {
		logic       operation;
		logic [7:0] char_in;
		logic [31:0] argument;
	} item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] char_out;
		logic       arg_consumed;
		logic       last;
	} result_t;

	typedef struct packed {
		logic        load;
		first_sel_t  first_sel;
		second_sel_t second_sel;
		logic        consumed;
		logic        fw_clear;
		logic        fw_step;
		logic        zf_set;
		logic        dig_step;
		logic        emit;
		emit_sel_t   emit_sel;
		logic        emit_last;
	} cmd_t;

	typedef struct packed {
		logic op;
		logic c_nul;
		logic c_pct;
		logic c_lf;
		logic c_digit;
		logic c_zero;
		logic c_num;
		logic c_str;
		logic c_chr;
		logic quot_zero;
		logic idx_zero;
		logic out_free;
	} status_t;

endpackage

// File: rtl/fsf_dp.sv
module fsf_dp
	import fsf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  item_t   item,
	input  cmd_t    cmd,
	output status_t st,
	input  logic    result_stall,
	output logic    result_valid,
	output result_t result
);

	logic [7:0]         char_q;
	logic [31:0]        val_q;
	first_sel_t         first_q;
	second_sel_t        second_q;
	logic               consumed_q;
	base_t              base_q;
	logic [3:0]         dig_q [DIG_MAX];
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   idx_q;
	logic [FW_W-1:0]    fw_q;
	logic               zf_q;
	result_t            out_q;
	logic               out_valid_q;

	base_t              base_in;
	logic [63:0]        prod;
	logic [31:0]        quot;
	logic [3:0]         rem;
	logic [7:0]         fw_acc;
	logic [FW_W-1:0]    fw_next;
	logic [CNT_W-1:0]   cnt_next;
	logic [CNT_W-1:0]   fw_ext;
	logic [CNT_W-1:0]   total;
	logic [7:0]         digit_char;
	result_t            res_next;

	// Classify the incoming character.
	always_comb begin
		st.op = item.operation;
		st.c_nul = (item.char_in == CH_NUL);
		st.c_pct = (item.char_in == CH_PCT);
		st.c_lf = (item.char_in == CH_LF);
		st.c_digit = (item.char_in >= CH_ZERO) && (item.char_in <= CH_NINE);
		st.c_zero = (item.char_in == CH_ZERO);
		st.quot_zero = (quot == 32'd0);
		st.idx_zero = (idx_q == '0);
		st.out_free = !out_valid_q || !result_stall;
		st.c_num = 1'b0;
		st.c_str = 1'b0;
		st.c_chr = 1'b0;
		base_in = BASE_DEC;
		case (item.char_in) inside
			"d", "u", "D", "U": st.c_num = 1'b1;
			"x", "X": begin
				st.c_num = 1'b1;
				base_in = BASE_HEX;
			end
			"o", "O": begin
				st.c_num = 1'b1;
				base_in = BASE_OCT;
			end
			"s": st.c_str = 1'b1;
			"c": st.c_chr = 1'b1;
			default: ;
		endcase
	end

	// One digit per cycle; decimal uses a reciprocal multiply.
	assign prod = 64'(val_q) * 64'(RECIP10);
	always_comb begin
		case (base_q)
			BASE_HEX: begin
				quot = val_q >> 4;
				rem = val_q[3:0];
			end
			BASE_OCT: begin
				quot = val_q >> 3;
				rem = {1'b0, val_q[2:0]};
			end
			default: begin
				quot = 32'(prod >> 35);
				rem = 4'(val_q - ((quot << 3) + (quot << 1)));
			end
		endcase
	end

	// Width digits saturate at the maximum field width.
	assign fw_acc = 8'(fw_q) * 8'd10 + (item.char_in - CH_ZERO);
	assign fw_next = (fw_acc > 8'(MAX_WIDTH)) ? FW_W'(MAX_WIDTH) : fw_acc[FW_W-1:0];

	assign cnt_next = cnt_q + 1'b1;
	assign fw_ext = CNT_W'(fw_q);
	assign total = (cnt_next > fw_ext) ? cnt_next : fw_ext;

	assign digit_char = (idx_q < cnt_q) ? HEX_DIGITS[dig_q[idx_q[DIG_IDX_W-1:0]]]
		: (zf_q ? CH_ZERO : CH_SPACE);

	always_comb begin
		res_next.kind = KIND_CHAR;
		res_next.char_out = CH_NUL;
		res_next.last = cmd.emit_last;
		res_next.arg_consumed = cmd.emit_last && consumed_q;
		case (cmd.emit_sel)
			EMIT_FIRST: res_next.char_out = (first_q == FIRST_PCT) ? CH_PCT : CH_CR;
			EMIT_DIGIT: res_next.char_out = digit_char;
			default: begin
				case (second_q)
					SEC_CHAR: res_next.char_out = char_q;
					SEC_PCT: res_next.char_out = CH_PCT;
					SEC_ARG: res_next.char_out = val_q[7:0];
					SEC_END: res_next.kind = KIND_END;
					default: res_next.kind = KIND_STR_REQ;
				endcase
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= '0;
			zf_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.fw_clear) begin
				fw_q <= '0;
				zf_q <= 1'b0;
			end else if (cmd.fw_step) begin
				fw_q <= fw_next;
				if (cmd.zf_set) begin
					zf_q <= 1'b1;
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			char_q <= item.char_in;
			val_q <= item.argument;
			first_q <= cmd.first_sel;
			second_q <= cmd.second_sel;
			consumed_q <= cmd.consumed;
			base_q <= base_in;
			cnt_q <= '0;
		end else if (cmd.dig_step) begin
			dig_q[cnt_q[DIG_IDX_W-1:0]] <= rem;
			val_q <= quot;
			cnt_q <= cnt_next;
			if (quot == 32'd0) begin
				idx_q <= total - 1'b1;
			end
		end else if (cmd.emit && cmd.emit_sel == EMIT_DIGIT) begin
			idx_q <= idx_q - 1'b1;
		end
		if (cmd.emit) begin
			out_q <= res_next;
		end
	end

	assign result_valid = out_valid_q;
	assign result = out_q;

endmodule

// File: rtl/fsf_ctrl.sv
module fsf_ctrl
	import fsf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  status_t st,
	output cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_DIG  = 4'b0010,
		S_NUM  = 4'b0100,
		S_FIX  = 4'b1000
	} state_t;

	typedef enum logic [3:0] {
		M_TEXT  = 4'b0001,
		M_PCT   = 4'b0010,
		M_WIDTH = 4'b0100,
		M_STR   = 4'b1000
	} mode_t;

	state_t state_q, state_d;
	mode_t  mode_q, mode_d, mode_eff;
	logic   two_q, two_d;
	logic   accept;

	assign item_stall = (state_q != S_IDLE);
	assign accept = item_valid && (state_q == S_IDLE);
	// A format character ends a string argument that is still open.
	assign mode_eff = (mode_q == M_STR) ? M_TEXT : mode_q;

	always_comb begin
		cmd = '0;
		cmd.first_sel = FIRST_CR;
		cmd.second_sel = SEC_CHAR;
		cmd.emit_sel = EMIT_FIRST;
		state_d = state_q;
		mode_d = mode_q;
		two_d = two_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					if (st.op) begin
						if (mode_q == M_STR) begin
							if (st.c_nul) begin
								mode_d = M_TEXT;
							end else begin
								state_d = S_FIX;
								two_d = st.c_lf;
							end
						end
					end else begin
						mode_d = mode_eff;
						if (mode_eff == M_TEXT) begin
							if (st.c_nul) begin
								state_d = S_FIX;
								two_d = 1'b0;
								cmd.second_sel = SEC_END;
							end else if (st.c_pct) begin
								mode_d = M_PCT;
								cmd.fw_clear = 1'b1;
							end else begin
								state_d = S_FIX;
								two_d = st.c_lf;
							end
						end else if (st.c_digit) begin
							cmd.fw_step = 1'b1;
							cmd.zf_set = (mode_eff == M_PCT) && st.c_zero;
							mode_d = M_WIDTH;
						end else begin
							mode_d = M_TEXT;
							state_d = S_FIX;
							two_d = 1'b0;
							cmd.first_sel = FIRST_PCT;
							if (st.c_nul) begin
								two_d = 1'b1;
								cmd.second_sel = SEC_END;
							end else if (st.c_pct) begin
								cmd.second_sel = SEC_PCT;
							end else if (st.c_num) begin
								state_d = S_DIG;
								cmd.consumed = 1'b1;
							end else if (st.c_str) begin
								mode_d = M_STR;
								cmd.second_sel = SEC_REQ;
								cmd.consumed = 1'b1;
							end else if (st.c_chr) begin
								cmd.second_sel = SEC_ARG;
								cmd.consumed = 1'b1;
							end else begin
								two_d = 1'b1;
								cmd.consumed = 1'b1;
							end
						end
					end
				end
			end
			S_DIG: begin
				cmd.dig_step = 1'b1;
				if (st.quot_zero) begin
					state_d = S_NUM;
				end
			end
			S_NUM: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_sel = EMIT_DIGIT;
					cmd.emit_last = st.idx_zero;
					if (st.idx_zero) begin
						state_d = S_IDLE;
					end
				end
			end
			S_FIX: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					if (two_q) begin
						cmd.emit_sel = EMIT_FIRST;
						two_d = 1'b0;
					end else begin
						cmd.emit_sel = EMIT_SECOND;
						cmd.emit_last = 1'b1;
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q <= M_TEXT;
			two_q <= 1'b0;
		end else begin
			state_q <= state_d;
			mode_q <= mode_d;
			two_q <= two_d;
		end
	end

endmodule

// File: rtl/format_string_formatter.sv
// Channel  Handshake                    Payload
// item     item_valid / item_stall      item_t: operation, char_in, argument
// result   result_valid / result_stall  result_t: kind, char_out, arg_consumed, last
//
// One item is taken at a time; the next is accepted once the last result of the
// previous one sits in the output register. A plain character gives one result, a
// newline or any other two-result reply gives two, and a number conversion first
// divides out its D digits (up to 11) one digit per cycle, then emits max(D, width) results.
// Reset puts the parser in literal text mode with a cleared width and fill flag.
// A stalled result holds the controller until the output register frees up.
module format_string_formatter
	import fsf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	cmd_t    cmd;
	status_t st;

	fsf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.st         (st),
		.cmd        (cmd)
	);

	fsf_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.st           (st),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
	import fsf_pkg::*;

	localparam logic OP_FORMAT = 1'b0;
	localparam logic OP_STRING = 1'b1;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD = 200;
	localparam int TAIL_CYCLES = 40;

	typedef enum logic [1:0] {
		P_TEXT  = 2'd0,
		P_PCT   = 2'd1,
		P_WIDTH = 2'd2,
		P_STR   = 2'd3
	} parse_mode_t;

	class fmt_scoreboard;
		parse_mode_t mode;
		int          width;
		bit          pad_zero;
		result_t     expected_q[$];
		int          errors;

		function new();
			mode = P_TEXT;
			width = 0;
			pad_zero = 1'b0;
			errors = 0;
		endfunction

		function int outstanding();
			return expected_q.size();
		endfunction

		function void push_result(kind_t k, logic [7:0] ch);
			result_t r;
			r.kind = k;
			r.char_out = (k == KIND_CHAR) ? ch : 8'h00;
			r.arg_consumed = 1'b0;
			r.last = 1'b0;
			expected_q.push_back(r);
		endfunction

		// A newline goes out as CR then LF.
		function void push_text(logic [7:0] ch);
			if (ch == CH_LF)
				push_result(KIND_CHAR, CH_CR);
			push_result(KIND_CHAR, ch);
		endfunction

		function void push_number(logic [31:0] value, int radix);
			logic [7:0]  digit_q[$];
			logic [31:0] rest;
			rest = value;
			if (rest == 0)
				digit_q.push_back(CH_ZERO);
			while (rest != 0) begin
				digit_q.push_back(HEX_DIGITS[rest % radix]);
				rest = rest / radix;
			end
			while (digit_q.size() < width)
				digit_q.push_back(pad_zero ? CH_ZERO : CH_SPACE);
			for (int i = digit_q.size() - 1; i >= 0; i--)
				push_result(KIND_CHAR, digit_q[i]);
		endfunction

		function void note_item(item_t it);
			logic [7:0] c;
			int         first;
			bit         consumed;
			int         w;
			c = it.char_in;
			first = expected_q.size();
			consumed = 1'b0;
			if (it.operation == OP_STRING) begin
				if (mode == P_STR) begin
					if (c == CH_NUL)
						mode = P_TEXT;
					else
						push_text(c);
				end
			end else begin
				// A format character ends a pending string on its own.
				if (mode == P_STR)
					mode = P_TEXT;
				if (mode == P_TEXT) begin
					if (c == CH_NUL) begin
						push_result(KIND_END, CH_NUL);
					end else if (c == CH_PCT) begin
						mode = P_PCT;
						width = 0;
						pad_zero = 1'b0;
					end else begin
						push_text(c);
					end
				end else if (c >= CH_ZERO && c <= CH_NINE) begin
					if (mode == P_PCT && c == CH_ZERO)
						pad_zero = 1'b1;
					w = width * 10 + (c - CH_ZERO);
					width = (w > MAX_WIDTH) ? MAX_WIDTH : w;
					mode = P_WIDTH;
				end else begin
					mode = P_TEXT;
					consumed = 1'b1;
					case (c)
						CH_NUL: begin
							push_result(KIND_CHAR, CH_PCT);
							push_result(KIND_END, CH_NUL);
							consumed = 1'b0;
						end
						CH_PCT: begin
							push_result(KIND_CHAR, CH_PCT);
							consumed = 1'b0;
						end
						"d", "u", "D", "U": push_number(it.argument, 10);
						"x", "X": push_number(it.argument, 16);
						"o", "O": push_number(it.argument, 8);
						"s": begin
							push_result(KIND_STR_REQ, CH_NUL);
							mode = P_STR;
						end
						"c": push_result(KIND_CHAR, it.argument[7:0]);
						default: begin
							push_result(KIND_CHAR, CH_PCT);
							push_result(KIND_CHAR, c);
						end
					endcase
				end
			end
			if (expected_q.size() > first) begin
				expected_q[expected_q.size() - 1].last = 1'b1;
				expected_q[expected_q.size() - 1].arg_consumed = consumed;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				$error("unexpected result: kind %0d char_out 0x%02h", got.kind, got.char_out);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.kind !== want.kind) begin
				$error("kind: expected %0d, actual %0d", want.kind, got.kind);
				errors++;
			end
			if (got.char_out !== want.char_out) begin
				$error("char_out: expected 0x%02h, actual 0x%02h", want.char_out, got.char_out);
				errors++;
			end
			if (got.arg_consumed !== want.arg_consumed) begin
				$error("arg_consumed: expected %0b, actual %0b", want.arg_consumed,
					got.arg_consumed);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0b, actual %0b", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	fmt_scoreboard board;
	int    sender_idle_pct = 28;
	int    receiver_idle_pct = 49;
	int    hold_token = 0;
	int    hold_seen = 0;
	int    hold_left = 0;
	int    quiet_cycles = 0;
	int    items_sent = 0;
	string conv_chars = "duDUxXoOcs%";

	format_string_formatter DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Receiver side: random stalls, plus one long hold-off on request.
	always @(negedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < receiver_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall)
				board.check_result(result);
			if (item_valid && !item_stall)
				board.note_item(item);
			if ((result_valid && !result_stall) || (item_valid && !item_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	function automatic logic [31:0] rand_arg();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(99);
			2: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
			default: return $urandom >> $urandom_range(31);
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_item(input logic op, input logic [7:0] ch, input logic [31:0] arg);
		item_t it;
		it.operation = op;
		it.char_in = ch;
		it.argument = arg;
		while ($urandom_range(99) < sender_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do
			@(posedge clk);
		while (!(item_valid && !item_stall));
		@(negedge clk);
		items_sent++;
	endtask

	task automatic send_format_text(input string s, input logic [31:0] arg);
		for (int i = 0; i < s.len(); i++)
			send_item(OP_FORMAT, s[i], arg);
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		do
			@(negedge clk);
		while (board.outstanding() != 0);
	endtask

	task automatic directed_items();
		send_format_text("\n", rand_arg());
		send_item(OP_FORMAT, 8'hFF, rand_arg());
		send_format_text("%d", 32'h0);
		send_format_text("%09x", 32'hFFFF_FFFF);
		// Width 29 saturates; the octal rendering fills it exactly.
		send_format_text("%29o", 32'hFFFF_FFFF);
		send_format_text("%c", 32'h1234_5641);
		send_format_text("%%", rand_arg());
		send_format_text("%q", rand_arg());
		send_format_text("%s", rand_arg());
		send_item(OP_STRING, CH_LF, rand_arg());
		send_item(OP_STRING, CH_NUL, rand_arg());
		// A string character with no string requested is dropped.
		send_item(OP_STRING, "z", rand_arg());
		send_format_text("%sB", rand_arg());
		send_format_text("%", rand_arg());
		send_item(OP_FORMAT, CH_NUL, rand_arg());
		send_item(OP_FORMAT, CH_NUL, rand_arg());
	endtask

	task automatic random_segment();
		int         pick;
		int         count;
		logic [7:0] ch;
		logic [31:0] arg;
		arg = rand_arg();
		pick = $urandom_range(99);
		if (pick < 30) begin
			ch = ($urandom_range(3) == 0) ? CH_LF : 8'($urandom_range(255, 1));
			if (ch == CH_PCT)
				ch = CH_LF;
			send_item(OP_FORMAT, ch, arg);
		end else if (pick < 70) begin
			send_item(OP_FORMAT, CH_PCT, arg);
			count = $urandom_range(2);
			for (int i = 0; i < count; i++)
				send_item(OP_FORMAT, CH_ZERO + 8'($urandom_range(9)), arg);
			if ($urandom_range(9) == 0) begin
				ch = 8'($urandom_range(255));
				if (ch >= CH_ZERO && ch <= CH_NINE)
					ch = "q";
			end else begin
				ch = conv_chars[$urandom_range(conv_chars.len() - 1)];
			end
			send_item(OP_FORMAT, ch, arg);
		end else if (pick < 85) begin
			send_format_text("%s", arg);
			count = $urandom_range(6);
			for (int i = 0; i < count; i++) begin
				ch = ($urandom_range(4) == 0) ? CH_LF : 8'($urandom_range(255, 1));
				send_item(OP_STRING, ch, rand_arg());
			end
			// Otherwise the next format character ends the string.
			if ($urandom_range(3) != 0)
				send_item(OP_STRING, CH_NUL, rand_arg());
		end else begin
			send_item(1'($urandom_range(1)), 8'($urandom_range(255)), arg);
		end
	endtask

	task automatic random_items(input int target);
		int stop_at;
		stop_at = items_sent + target;
		while (items_sent < stop_at)
			random_segment();
	endtask

	initial begin
		board = new();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		directed_items();
		random_items(40);
		wait_drained();

		sender_idle_pct = 49;
		receiver_idle_pct = 28;
		random_items(20);
		// Hold the receiver off while items keep coming so the block backs up.
		hold_token++;
		random_items(20);
		wait_drained();
		random_items(20);
		wait_drained();

		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		random_items(40);
		wait_drained();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.outstanding() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// File: sim.f
rtl/fsf_pkg.sv
rtl/fsf_dp.sv
rtl/fsf_ctrl.sv
rtl/format_string_formatter.sv
tb/sv/tb.sv
